/* design/scmcv_pkg.sv */
package scmcv_pkg;

   localparam int NUM_SCENES_DEF   = 16;
   localparam int NUM_CHANNELS_DEF = 16;

   // command codes
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_SCENE  = 2'd1;
   localparam logic [1:0] CMD_MANUAL = 2'd2;

   // register index of the bipolar switch
   localparam logic REG_BIPOLAR = 1'b0;

   localparam logic [14:0] FULL_MORPH    = 15'd20480;
   localparam int          HALF_MORPH    = 10240;
   localparam int          BIPOLAR_SHIFT = 10240;

   // floor(u / 5) = (u * DIV5_MULT) >> 24, exact for u < 2**22
   localparam logic [21:0] DIV5_MULT = 22'd3355444;
   // bias keeps the quotient input positive: 200000 = 5 * 40000
   localparam int          DIV5_BIAS = 200000;
   localparam int          QUOT_BIAS = 40000;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] target_cv;
      logic [3:0]         target_knob;
      logic signed [15:0] current_cv;
      logic [3:0]         current_knob;
      logic signed [15:0] morph_cv;
      logic [14:0]        morph_knob;
      logic [15:0]        type_buttons;
      logic [15:0]        focus_mask;
      logic [3:0]         scene_slot;
      logic [3:0]         channel_slot;
      logic [14:0]        write_value;
   } req_type;

   typedef struct packed {
      logic [3:0]         channel;
      logic signed [15:0] cv_out;
      logic               type_light;
      logic               last;
   } rsp_type;

endpackage

/* design/scmcv_ram.sv */
module scmcv_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

/* design/scene_morph_cv_engine_core.sv */
// Channel   Ports                                 Direction  Transaction
// request   start, busy, req_payload              in         start & !busy
// result    rsp_strobe, rsp_payload               out        every strobe cycle
// config    psel, penable, pwrite, paddr, pwdata  in         APB access phase
//
// A tick keeps busy high while N = min(NUM_CHANNELS, 16) channels are processed: each channel
// goes read, multiply, divide, emit through the single shared multiplier.
// Write commands land in the store at acceptance; busy stays low.
// After reset a clearing sweep over all 2**(ROW_W+CH_W) store entries (512 by default)
// zeroes the store and manual row; start is not taken meanwhile.
// Results are one cycle each on the strobe; the receiver cannot stall.
module scene_morph_cv_engine_core import scmcv_pkg::*; #(
   parameter int NUM_SCENES   = NUM_SCENES_DEF,
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   output logic        rsp_strobe,
   output rsp_type     rsp_payload,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int SC_W  = $clog2(NUM_SCENES);
   localparam int ROW_W = $clog2(NUM_SCENES + 1);
   localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int AW    = ROW_W + CH_W;
   localparam int DEPTH = 2 ** AW;
   localparam int NOUT  = (NUM_CHANNELS < 16) ? NUM_CHANNELS : 16;
   localparam logic signed [7:0] SC_MAX  = 8'(NUM_SCENES - 1);
   localparam logic [ROW_W-1:0]  MAN_ROW = ROW_W'(NUM_SCENES);
   localparam logic [3:0]        LAST_CH = 4'(NOUT - 1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CLEAR = 6'b000010,
      ST_READ  = 6'b000100,
      ST_MUL   = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   function automatic logic [SC_W-1:0] scene_idx(input logic signed [15:0] cv,
                                                 input logic [3:0] knob);
      logic signed [17:0] cv3;
      logic [17:0]        sum;
      logic signed [7:0]  s;
      cv3 = {{2{cv[15]}}, cv} + {cv[15], cv, 1'b0};
      sum = 18'(cv3 + 18'sd98304);
      s   = $signed({2'b00, sum[17:12]}) - 8'sd24 + $signed({4'b0000, knob});
      if (s < 8'sd0) begin
         s = 8'sd0;
      end else if (s > SC_MAX) begin
         s = SC_MAX;
      end
      return s[SC_W-1:0];
   endfunction

   state_type          state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [3:0]         ch_ff, ch_in;
   logic [15:0]        flags_ff, flags_in;
   logic [15:0]        prev_ff, prev_in;
   logic               bipolar_ff, bipolar_in;
   logic [SC_W-1:0]    cur_ff, cur_in;
   logic [SC_W-1:0]    tgt_ff, tgt_in;
   logic [14:0]        morph_ff, morph_in;
   logic [15:0]        focus_ff, focus_in;
   logic signed [47:0] prod_ff, prod_in;

   logic               accept;
   logic               tick_go;
   logic               wr_go;
   logic               slot_ok;
   logic [ROW_W-1:0]   wr_row;
   logic signed [16:0] morph_sum;
   logic [14:0]        morph_clamp;
   logic               cfg_wr;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [14:0]        ram_wdata;
   logic [AW-1:0]      raddr_a;
   logic [AW-1:0]      raddr_b;
   logic [14:0]        rdata_a;
   logic [14:0]        rdata_b;
   logic [CH_W-1:0]    ch_addr;

   logic signed [23:0] op_a;
   logic signed [23:0] op_b;
   logic signed [47:0] mul_out;
   logic signed [15:0] diff;
   logic signed [32:0] p_round;
   logic signed [20:0] q_biased;
   logic [18:0]        u_val;
   logic signed [17:0] glide_ofs;
   logic signed [17:0] val;
   logic signed [17:0] val_out;
   logic               focused;

   // ---------------- request decode ----------------
   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign tick_go = accept && (req_payload.cmd == CMD_TICK);

   always_comb begin
      slot_ok = 1'b0;
      wr_row  = MAN_ROW;
      case (req_payload.cmd)
         CMD_SCENE: begin
            slot_ok = (7'(req_payload.scene_slot) < 7'(NUM_SCENES)) &&
                      (7'(req_payload.channel_slot) < 7'(NUM_CHANNELS));
            wr_row  = ROW_W'(req_payload.scene_slot);
         end
         CMD_MANUAL: begin
            slot_ok = (7'(req_payload.channel_slot) < 7'(NUM_CHANNELS));
            wr_row  = MAN_ROW;
         end
         default: begin
            slot_ok = 1'b0;
            wr_row  = MAN_ROW;
         end
      endcase
   end

   assign wr_go = accept && slot_ok;

   assign morph_sum = {req_payload.morph_cv[15], req_payload.morph_cv}
                    + $signed({2'b00, req_payload.morph_knob});

   always_comb begin
      if (morph_sum < 17'sd0) begin
         morph_clamp = 15'd0;
      end else if (morph_sum > $signed({2'b00, FULL_MORPH})) begin
         morph_clamp = FULL_MORPH;
      end else begin
         morph_clamp = morph_sum[14:0];
      end
   end

   // ---------------- config port ----------------
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BIPOLAR);
   assign bipolar_in = cfg_wr ? pwdata[0] : bipolar_ff;
   assign prdata = (paddr[2] == REG_BIPOLAR) ? {31'd0, bipolar_ff} : 32'd0;

   // ---------------- store ----------------
   assign ch_addr = CH_W'(ch_ff);
   assign focused = focus_ff[ch_ff];
   // port A carries the manual value for a focused channel, else the current scene
   assign raddr_a = {focused ? MAN_ROW : ROW_W'(cur_ff), ch_addr};
   assign raddr_b = {ROW_W'(tgt_ff), ch_addr};

   assign ram_we    = (state_ff == ST_CLEAR) || wr_go;
   assign ram_waddr = (state_ff == ST_CLEAR) ? clr_ff
                    : {wr_row, CH_W'(req_payload.channel_slot)};
   assign ram_wdata = (state_ff == ST_CLEAR) ? 15'd0 : req_payload.write_value;

   scmcv_ram #(
      .WIDTH (15),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   // ---------------- shared multiplier ----------------
   assign diff     = $signed({1'b0, rdata_b}) - $signed({1'b0, rdata_a});
   // floor((p + half) / 20480) = floor(floor((p + half) / 4096) / 5)
   assign p_round  = 33'(prod_ff[31:0]) + 33'sd10240;
   assign q_biased = p_round[32:12] + 21'(DIV5_BIAS);
   assign u_val    = q_biased[18:0];

   always_comb begin
      if (state_ff == ST_DIV) begin
         op_a = $signed({5'd0, u_val});
         op_b = $signed({2'b00, DIV5_MULT});
      end else begin
         op_a = $signed({9'd0, morph_ff});
         op_b = {{8{diff[15]}}, diff};
      end
   end

   assign mul_out = op_a * op_b;

   assign glide_ofs = $signed({1'b0, prod_ff[40:24]}) - 18'(QUOT_BIAS);

   always_comb begin
      if (focused) begin
         val = $signed({3'b000, rdata_a});
      end else if (!flags_ff[ch_ff]) begin
         val = $signed({3'b000, rdata_a}) + glide_ofs;
      end else if (morph_ff == FULL_MORPH) begin
         val = $signed({3'b000, rdata_b});
      end else begin
         val = $signed({3'b000, rdata_a});
      end
   end

   assign val_out = bipolar_ff ? (val - 18'(BIPOLAR_SHIFT)) : val;

   assign rsp_strobe             = (state_ff == ST_EMIT);
   assign rsp_payload.channel    = ch_ff;
   assign rsp_payload.cv_out     = val_out[15:0];
   assign rsp_payload.type_light = flags_ff[ch_ff];
   assign rsp_payload.last       = (ch_ff == LAST_CH);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      ch_in    = ch_ff;
      flags_in = flags_ff;
      prev_in  = prev_ff;
      cur_in   = cur_ff;
      tgt_in   = tgt_ff;
      morph_in = morph_ff;
      focus_in = focus_ff;
      prod_in  = prod_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (tick_go) begin
               state_in = ST_READ;
               ch_in    = 4'd0;
               flags_in = flags_ff ^ (req_payload.type_buttons & ~prev_ff);
               prev_in  = req_payload.type_buttons;
               cur_in   = scene_idx(req_payload.current_cv, req_payload.current_knob);
               tgt_in   = scene_idx(req_payload.target_cv, req_payload.target_knob);
               morph_in = morph_clamp;
               focus_in = req_payload.focus_mask;
            end
         end
         ST_READ: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = mul_out;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            prod_in  = mul_out;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (ch_ff == LAST_CH) begin
               state_in = ST_IDLE;
            end else begin
               ch_in    = ch_ff + 4'd1;
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         ch_ff      <= 4'd0;
         flags_ff   <= 16'd0;
         prev_ff    <= 16'd0;
         bipolar_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         ch_ff      <= ch_in;
         flags_ff   <= flags_in;
         prev_ff    <= prev_in;
         bipolar_ff <= bipolar_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      tgt_ff   <= tgt_in;
      morph_ff <= morph_in;
      focus_ff <= focus_in;
      prod_ff  <= prod_in;
   end

   // ---------------- assertions ----------------
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside a tick");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.last |=> !busy)
      else $error("still busy after the final result");

   a_chan_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_payload.last |-> ##4
         (rsp_strobe && (rsp_payload.channel == 4'($past(rsp_payload.channel, 4) + 4'd1))))
      else $error("channel sequence broken");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we && (state_ff != ST_CLEAR) |-> !busy)
      else $error("store written during a tick");

endmodule

/* verif/scene_morph_cv_engine_core_tb.sv */
module scene_morph_cv_engine_core_tb;
   import scmcv_pkg::*;

   localparam logic [1:0] CMD_IDLE = 2'd3;  // unused code, block ignores it
   localparam int         CYCLE_LIMIT = 300000;

   // keeps its own copy of the scene store, manual row and type bits
   class cv_morph_predictor;
      logic [14:0] scene_entry [16][16];
      logic [14:0] manual_entry [16];
      logic [15:0] step_flags;
      logic [15:0] last_buttons;
      bit          bipolar;
      rsp_type     expected_cv [$];

      function new();
         foreach (scene_entry[s, c]) scene_entry[s][c] = '0;
         foreach (manual_entry[c]) manual_entry[c] = '0;
         step_flags = '0;
         last_buttons = '0;
         bipolar = 1'b0;
      endfunction

      function void set_bipolar(bit on);
         bipolar = on;
      endfunction

      function int pending();
         return expected_cv.size();
      endfunction

      function int scene_pick(logic signed [15:0] cv, logic [3:0] knob);
         int s;
         s = ((int'(cv) * 3) >>> 12) + int'(knob);
         if (s < 0) s = 0;
         if (s > 15) s = 15;
         return s;
      endfunction

      function longint floor_div(longint num, longint den);
         if (num >= 0) return num / den;
         return -((-num + den - 1) / den);
      endfunction

      function void note_request(req_type r);
         int tgt, cur, morph, a, b, v;
         longint num;
         rsp_type o;
         case (r.cmd)
            CMD_SCENE: begin
               scene_entry[r.scene_slot][r.channel_slot] = r.write_value;
            end
            CMD_MANUAL: begin
               manual_entry[r.channel_slot] = r.write_value;
            end
            CMD_TICK: begin
               tgt = scene_pick(r.target_cv, r.target_knob);
               cur = scene_pick(r.current_cv, r.current_knob);
               step_flags = step_flags ^ (r.type_buttons & ~last_buttons);
               last_buttons = r.type_buttons;
               morph = int'(r.morph_cv) + int'(r.morph_knob);
               if (morph < 0) morph = 0;
               if (morph > int'(FULL_MORPH)) morph = int'(FULL_MORPH);
               for (int ch = 0; ch < 16; ch++) begin
                  a = int'(scene_entry[cur][ch]);
                  b = int'(scene_entry[tgt][ch]);
                  if (r.focus_mask[ch]) begin
                     v = int'(manual_entry[ch]);
                  end else if (!step_flags[ch]) begin
                     num = longint'(morph) * longint'(b - a) + longint'(HALF_MORPH);
                     v = a + int'(floor_div(num, longint'(FULL_MORPH)));
                  end else begin
                     v = (morph == int'(FULL_MORPH)) ? b : a;
                  end
                  if (bipolar) v = v - BIPOLAR_SHIFT;
                  o.channel = ch[3:0];
                  o.cv_out = v[15:0];
                  o.type_light = step_flags[ch];
                  o.last = (ch == 15);
                  expected_cv.push_back(o);
               end
            end
            default: begin
            end
         endcase
      endfunction

      function string check_output(rsp_type got);
         rsp_type want;
         if (expected_cv.size() == 0)
            return $sformatf("result on channel %0d with nothing pending", got.channel);
         want = expected_cv.pop_front();
         if (got.channel !== want.channel || got.cv_out !== want.cv_out ||
             got.type_light !== want.type_light || got.last !== want.last)
            return $sformatf({"got ch %0d cv %0d light %0b last %0b, ",
                              "want ch %0d cv %0d light %0b last %0b"},
                             got.channel, got.cv_out, got.type_light, got.last,
                             want.channel, want.cv_out, want.type_light, want.last);
         return "";
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_payload = '0;
   logic        rsp_strobe;
   rsp_type     rsp_payload;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   cv_morph_predictor predicted = new();
   int errors = 0;
   int cycles = 0;

   scene_morph_cv_engine_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic report_mismatch(string msg);
      $display("MISMATCH @%0d: %s", cycles, msg);
      errors++;
   endtask

   always @(posedge clock) begin : rsp_monitor
      string msg;
      if (!reset && rsp_strobe) begin
         msg = predicted.check_output(rsp_payload);
         if (msg != "") report_mismatch(msg);
      end
   end

   // holds start high until the transaction is taken
   task automatic send_req(req_type r);
      start <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      predicted.note_request(r);
   endtask

   task automatic idle_cycles(int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      while (predicted.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic csr_write(logic [31:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= 3'({REG_BIPOLAR, 2'b00});
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      predicted.set_bipolar(value[0]);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_type noise_fields();
      req_type r;
      r.cmd = 2'($urandom);
      r.target_cv = 16'($urandom);
      r.target_knob = 4'($urandom);
      r.current_cv = 16'($urandom);
      r.current_knob = 4'($urandom);
      r.morph_cv = 16'($urandom);
      r.morph_knob = 15'($urandom);
      r.type_buttons = 16'($urandom);
      r.focus_mask = 16'($urandom);
      r.scene_slot = 4'($urandom);
      r.channel_slot = 4'($urandom);
      r.write_value = 15'($urandom);
      return r;
   endfunction

   function automatic logic signed [15:0] rand_cv();
      int p;
      p = $urandom_range(0, 99);
      if (p < 80) return 16'($urandom_range(0, 40960) - 20480);
      if (p < 85) return -16'sd20480;
      if (p < 90) return 16'sd20480;
      return 16'($urandom);
   endfunction

   function automatic req_type tick_item(int tcv, int tk, int ccv, int ck, int mcv, int mk,
                                         logic [15:0] buttons, logic [15:0] focus);
      req_type r;
      r = noise_fields();
      r.cmd = CMD_TICK;
      r.target_cv = 16'(tcv);
      r.target_knob = 4'(tk);
      r.current_cv = 16'(ccv);
      r.current_knob = 4'(ck);
      r.morph_cv = 16'(mcv);
      r.morph_knob = 15'(mk);
      r.type_buttons = buttons;
      r.focus_mask = focus;
      return r;
   endfunction

   function automatic req_type write_item(logic [1:0] cmd, int scene, int ch, int value);
      req_type r;
      r = noise_fields();
      r.cmd = cmd;
      r.scene_slot = 4'(scene);
      r.channel_slot = 4'(ch);
      r.write_value = 15'(value);
      return r;
   endfunction

   function automatic req_type rand_item();
      req_type r;
      int p, q;
      r = noise_fields();
      p = $urandom_range(0, 99);
      if (p < 45) begin
         r.cmd = CMD_TICK;
         r.target_cv = rand_cv();
         r.current_cv = rand_cv();
         q = $urandom_range(0, 99);
         if (q < 25) begin
            r.morph_cv = '0;
            r.morph_knob = FULL_MORPH;
         end else if (q < 35) begin
            r.morph_cv = '0;
            r.morph_knob = '0;
         end else if (q < 90) begin
            r.morph_cv = rand_cv();
            r.morph_knob = 15'($urandom_range(0, 20480));
         end else begin
            r.morph_cv = rand_cv();
         end
         case ($urandom_range(0, 3))
            0: r.focus_mask = '0;
            1: r.focus_mask = '1;
            default: r.focus_mask = 16'($urandom);
         endcase
      end else if (p < 93) begin
         r.cmd = (p < 75) ? CMD_SCENE : CMD_MANUAL;
         if ($urandom_range(0, 99) < 85) r.write_value = 15'($urandom_range(0, 20480));
      end else begin
         r.cmd = CMD_IDLE;
      end
      return r;
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      csr_write(32'd0);

      // directed: store and manual extremes, then ticks across the corners
      send_req(write_item(CMD_SCENE, 0, 0, 32767));
      send_req(write_item(CMD_SCENE, 15, 0, 20480));
      send_req(write_item(CMD_SCENE, 15, 15, 12345));
      send_req(write_item(CMD_SCENE, 0, 15, 21845));
      send_req(write_item(CMD_SCENE, 1, 7, 1));
      send_req(write_item(CMD_MANUAL, 3, 3, 32767));
      send_req(write_item(CMD_MANUAL, 0, 15, 20480));
      // indices clamp low and high, no morph
      send_req(tick_item(20480, 15, -20480, 0, 0, 0, 16'h0000, 16'h0000));
      idle_cycles(2);
      // full morph, focused channels take manual values
      send_req(tick_item(20480, 15, -20480, 0, 0, 20480, 16'h0000, 16'h8008));
      // all channels toggle to step, mid morph keeps current entry
      send_req(tick_item(20480, 15, -20480, 0, 10240, 0, 16'hFFFF, 16'h0000));
      // buttons held: no toggle; zero morph keeps current entry
      send_req(tick_item(20480, 15, -1, 0, -20480, 20480, 16'hFFFF, 16'h0000));
      // release then press odd buttons; morph above full clamps
      send_req(tick_item(1366, 0, 1365, 1, 20480, 20480, 16'h0000, 16'h0000));
      send_req(tick_item(-1, 15, -20480, 0, 20480, 20480, 16'hAAAA, 16'h0000));
      send_req(write_item(CMD_IDLE, 2, 2, 777));
      // tiny morph, halves round upward
      send_req(tick_item(20480, 15, -20480, 0, 1, 0, 16'hAAAA, 16'h0000));
      send_req(tick_item(20480, 15, 0, 0, -20480, 20479, 16'hAAAA, 16'h7FFF));
      settle();
      csr_write(32'd1);
      send_req(tick_item(20480, 15, -20480, 0, 0, 10240, 16'h5555, 16'h0000));
      send_req(tick_item(0, 0, 0, 0, 0, 0, 16'h0000, 16'hFFFF));
      settle();

      for (int ph = 0; ph < 4; ph++) begin
         csr_write(32'(ph % 2));
         for (int n = 0; n < 100; n++) begin
            send_req(rand_item());
            if (ph != 2) idle_cycles(gap_len());
         end
         settle();
      end

      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
